FILE: rtl/rqe_pkg.sv
package rqe_pkg;

  // field widths and fixed-point formats
  localparam int QuatW   = 16;
  localparam int AngleW  = 16;
  localparam int PitchW  = 15;
  localparam int QuatFb  = 14;
  localparam int AngleFb = 13;
  localparam int WorkFb  = 30;

  // datapath widths
  localparam int RW    = 20;  // relative quaternion component
  localparam int OpW   = 32;  // multiplier operand
  localparam int ProdW = 64;  // multiplier product
  localparam int AccW  = 42;  // product accumulator
  localparam int MatW  = 33;  // matrix entry in Q30, saturated to [-2, 2]
  localparam int SW    = 32;  // asin argument in Q30, saturated to [-1, 1]
  localparam int CorW  = 36;  // cordic x, y, z
  localparam int RadW  = 61;  // square root radicand and root

  // multiply sequence
  localparam int StepW   = 5;
  localparam int MatStep = 16;  // first step of the matrix products
  localparam int SqStep  = 26;  // squaring of the asin argument

  // quaternion component codes
  localparam logic [1:0] CW = 2'd0;
  localparam logic [1:0] CX = 2'd1;
  localparam logic [1:0] CY = 2'd2;
  localparam logic [1:0] CZ = 2'd3;

  // product sign codes
  localparam logic OpAdd = 1'b0;
  localparam logic OpSub = 1'b1;

  localparam logic signed [CorW-1:0] PiQ30     = 36'sd3373259426;
  localparam logic signed [CorW-1:0] HalfPiQ30 = 36'sd1686629713;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL   = 7'b0000010,
    S_ROLL  = 7'b0000100,
    S_YAW   = 7'b0001000,
    S_SQRT  = 7'b0010000,
    S_PITCH = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic [1:0] a_sel;
    logic [1:0] b_sel;
    logic       neg;
    logic       first;
    logic       last;
  } mstep_t;

  // one product per step: conj(p) * q, then the rotation matrix terms, then the square of the asin argument
  function automatic mstep_t mul_step(input logic [StepW-1:0] k);
    mstep_t s;
    case (k)
      5'd0:  s = '{CW, CW, OpAdd, 1'b1, 1'b0};
      5'd1:  s = '{CX, CX, OpAdd, 1'b0, 1'b0};
      5'd2:  s = '{CY, CY, OpAdd, 1'b0, 1'b0};
      5'd3:  s = '{CZ, CZ, OpAdd, 1'b0, 1'b1};
      5'd4:  s = '{CW, CX, OpAdd, 1'b1, 1'b0};
      5'd5:  s = '{CX, CW, OpSub, 1'b0, 1'b0};
      5'd6:  s = '{CY, CZ, OpSub, 1'b0, 1'b0};
      5'd7:  s = '{CZ, CY, OpAdd, 1'b0, 1'b1};
      5'd8:  s = '{CW, CY, OpAdd, 1'b1, 1'b0};
      5'd9:  s = '{CX, CZ, OpAdd, 1'b0, 1'b0};
      5'd10: s = '{CY, CW, OpSub, 1'b0, 1'b0};
      5'd11: s = '{CZ, CX, OpSub, 1'b0, 1'b1};
      5'd12: s = '{CW, CZ, OpAdd, 1'b1, 1'b0};
      5'd13: s = '{CX, CY, OpSub, 1'b0, 1'b0};
      5'd14: s = '{CY, CX, OpAdd, 1'b0, 1'b0};
      5'd15: s = '{CZ, CW, OpSub, 1'b0, 1'b1};
      5'd16: s = '{CY, CY, OpAdd, 1'b1, 1'b0};
      5'd17: s = '{CZ, CZ, OpAdd, 1'b0, 1'b1};
      5'd18: s = '{CX, CY, OpAdd, 1'b1, 1'b0};
      5'd19: s = '{CW, CZ, OpAdd, 1'b0, 1'b1};
      5'd20: s = '{CX, CZ, OpAdd, 1'b1, 1'b0};
      5'd21: s = '{CW, CY, OpSub, 1'b0, 1'b1};
      5'd22: s = '{CY, CZ, OpAdd, 1'b1, 1'b0};
      5'd23: s = '{CW, CX, OpAdd, 1'b0, 1'b1};
      5'd24: s = '{CX, CX, OpAdd, 1'b1, 1'b0};
      5'd25: s = '{CY, CY, OpAdd, 1'b0, 1'b1};
      5'd26: s = '{CW, CW, OpAdd, 1'b1, 1'b0};
      default: s = '{CW, CW, OpAdd, 1'b0, 1'b0};
    endcase
    return s;
  endfunction

  // atan(2^-i) in Q30, rounded to nearest
  function automatic logic [29:0] atan_entry(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      5'd26: v = 30'd16;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/rqe_intf.sv
// orientation quaternion channel
interface rqe_quat_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [rqe_pkg::QuatW-1:0]         quat_w;
  logic signed [rqe_pkg::QuatW-1:0]         quat_x;
  logic signed [rqe_pkg::QuatW-1:0]         quat_y;
  logic signed [rqe_pkg::QuatW-1:0]         quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// euler angle channel
interface rqe_euler_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [rqe_pkg::AngleW-1:0]        roll_angle;
  logic signed [rqe_pkg::PitchW-1:0]        pitch_angle;
  logic signed [rqe_pkg::AngleW-1:0]        yaw_angle;

  modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

FILE: rtl/relative_quaternion_to_euler.sv
// Each item runs its products on a shared multiplier, then one cordic step per cycle
// for each of three angles and one root bit per cycle in the square root. An item is
// taken only while idle, so a new item waits until the last result has gone to the
// output register; the first item after reset is only stored and gives no result.
// A finished result waits in the output register while the next item is taken.
// Reset clears state and valids.
module relative_quaternion_to_euler #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rqe_quat_if.sink          quat_i,
  rqe_euler_if.source       euler_o
);

  localparam int IterW = $clog2(CORDIC_ITERATIONS + 1);

  rqe_pkg::state_e state_q;
  logic [rqe_pkg::StepW-1:0] step_q, pk_q;
  logic                      pvalid_q;
  logic                      have_prev_q;
  logic                      out_valid_q;
  logic [IterW-1:0]          it_q;

  logic signed [rqe_pkg::QuatW-1:0] pq_q [4];
  logic signed [rqe_pkg::QuatW-1:0] cq_q [4];
  logic signed [rqe_pkg::RW-1:0]    r_q  [4];
  logic signed [rqe_pkg::MatW-1:0]  mat_q [5];
  logic signed [rqe_pkg::ProdW-1:0] prod_q;
  rqe_pkg::mstep_t                  pstep_q;
  logic signed [rqe_pkg::AccW-1:0]  acc_q;
  logic signed [rqe_pkg::SW-1:0]    s_q;
  logic [rqe_pkg::RadW-1:0]         rad_q, root_q, bit_q;
  logic signed [rqe_pkg::CorW-1:0]  cx_q, cy_q, cz_q;
  logic                             zero_q;
  logic signed [rqe_pkg::AngleW-1:0] roll_a_q, yaw_a_q, roll_o_q, yaw_o_q;
  logic signed [rqe_pkg::PitchW-1:0] pitch_a_q, pitch_o_q;

  logic in_acc, out_acc;
  assign quat_i.ready = (state_q == rqe_pkg::S_IDLE);
  assign in_acc  = quat_i.valid && quat_i.ready;
  assign out_acc = euler_o.valid && euler_o.ready;

  assign euler_o.valid       = out_valid_q;
  assign euler_o.roll_angle  = roll_o_q;
  assign euler_o.pitch_angle = pitch_o_q;
  assign euler_o.yaw_angle   = yaw_o_q;

  // asin argument: -m20 saturated to [-1, 1]
  logic signed [rqe_pkg::MatW:0] nm20;
  logic signed [rqe_pkg::SW-1:0] s_c;
  always_comb begin
    nm20 = -(rqe_pkg::MatW+1)'(mat_q[2]);
    if (nm20 > (rqe_pkg::MatW+1)'(1 <<< rqe_pkg::WorkFb)) begin
      s_c = rqe_pkg::SW'(1 <<< rqe_pkg::WorkFb);
    end else if (nm20 < -(rqe_pkg::MatW+1)'(1 <<< rqe_pkg::WorkFb)) begin
      s_c = -rqe_pkg::SW'(1 <<< rqe_pkg::WorkFb);
    end else begin
      s_c = rqe_pkg::SW'(nm20);
    end
  end

  // multiply issue: operands from the quaternions, the relative rotation or s
  rqe_pkg::mstep_t ms;
  logic issue;
  logic signed [rqe_pkg::OpW-1:0]   op_a, op_b;
  logic signed [rqe_pkg::ProdW-1:0] prod_d;

  assign ms    = rqe_pkg::mul_step(step_q);
  assign issue = (state_q == rqe_pkg::S_MUL) &&
                 (step_q <= rqe_pkg::StepW'(rqe_pkg::SqStep));

  always_comb begin
    if (step_q < rqe_pkg::StepW'(rqe_pkg::MatStep)) begin
      op_a = rqe_pkg::OpW'(pq_q[ms.a_sel]);
      op_b = rqe_pkg::OpW'(cq_q[ms.b_sel]);
    end else if (step_q < rqe_pkg::StepW'(rqe_pkg::SqStep)) begin
      op_a = rqe_pkg::OpW'(r_q[ms.a_sel]);
      op_b = rqe_pkg::OpW'(r_q[ms.b_sel]);
    end else begin
      op_a = s_c;
      op_b = s_c;
    end
  end
  assign prod_d = op_a * op_b;

  // accumulate, round to the relative rotation, finish matrix entries
  logic signed [rqe_pkg::AccW-1:0] term, acc_sum, rnd;
  logic signed [rqe_pkg::AccW+1:0] twice, mx;
  logic signed [rqe_pkg::AccW+1:0] sat_lim;
  logic [2:0]                      grp;
  logic                            diag;
  logic signed [rqe_pkg::MatW-1:0] m_new;
  logic signed [rqe_pkg::RW-1:0]   r_new;
  logic                            mul_end;

  always_comb begin
    term    = (pstep_q.neg == rqe_pkg::OpSub) ? -rqe_pkg::AccW'(prod_q)
                                              : rqe_pkg::AccW'(prod_q);
    acc_sum = pstep_q.first ? term : acc_q + term;
    rnd     = acc_sum + rqe_pkg::AccW'(1 <<< (rqe_pkg::QuatFb - 1));
    r_new   = rnd[rqe_pkg::QuatFb +: rqe_pkg::RW];
    grp     = 3'((pk_q - rqe_pkg::StepW'(rqe_pkg::MatStep)) >> 1);
    diag    = (grp == 3'd0) || (grp == 3'd4);
    twice   = {acc_sum[rqe_pkg::AccW-1], acc_sum, 1'b0};
    mx      = diag ? (rqe_pkg::AccW+2)'(1 <<< (2*rqe_pkg::QuatFb)) - twice : twice;
    sat_lim = (rqe_pkg::AccW+2)'(2 <<< (2*rqe_pkg::QuatFb));
    if (mx > sat_lim) begin
      mx = sat_lim;
    end else if (mx < -sat_lim) begin
      mx = -sat_lim;
    end
    m_new   = {mx[rqe_pkg::MatW-3:0], 2'b00};
  end
  assign mul_end = (state_q == rqe_pkg::S_MUL) && pvalid_q &&
                   (pk_q == rqe_pkg::StepW'(rqe_pkg::SqStep));

  // square root, one root bit per cycle
  logic [rqe_pkg::RadW-1:0] sq_sum;
  logic                     sqrt_end;
  assign sq_sum   = root_q + bit_q;
  assign sqrt_end = (state_q == rqe_pkg::S_SQRT) && (bit_q == '0);

  // cordic start values: pre-rotation by pi for a negative x
  logic cor_state, cor_run, cor_end, cor_start;
  logic signed [rqe_pkg::CorW-1:0] iy, ix, ix0, iy0, iz0;
  logic                            izero;

  assign cor_state = (state_q == rqe_pkg::S_ROLL) || (state_q == rqe_pkg::S_YAW) ||
                     (state_q == rqe_pkg::S_PITCH);
  assign cor_run   = cor_state && (it_q != IterW'(CORDIC_ITERATIONS));
  assign cor_end   = cor_state && (it_q == IterW'(CORDIC_ITERATIONS));
  assign cor_start = mul_end || sqrt_end || (cor_end && (state_q == rqe_pkg::S_ROLL));

  always_comb begin
    if (state_q == rqe_pkg::S_MUL) begin
      iy = rqe_pkg::CorW'(mat_q[3]);
      ix = rqe_pkg::CorW'(mat_q[4]);
    end else if (state_q == rqe_pkg::S_ROLL) begin
      iy = rqe_pkg::CorW'(mat_q[1]);
      ix = rqe_pkg::CorW'(mat_q[0]);
    end else begin
      iy = rqe_pkg::CorW'(s_q);
      ix = {1'b0, root_q[rqe_pkg::CorW-2:0]};
    end
    izero = (ix == '0) && (iy == '0);
    if (ix < 0) begin
      ix0 = -ix;
      iy0 = -iy;
      iz0 = (iy >= 0) ? rqe_pkg::PiQ30 : -rqe_pkg::PiQ30;
    end else begin
      ix0 = ix;
      iy0 = iy;
      iz0 = '0;
    end
  end

  // cordic step
  logic signed [rqe_pkg::CorW-1:0] dx, dy, at;
  assign dx = cx_q >>> it_q;
  assign dy = cy_q >>> it_q;
  assign at = rqe_pkg::CorW'(rqe_pkg::atan_entry(5'(it_q)));

  // angle clamp and rounding to the output format
  logic signed [rqe_pkg::CorW-1:0] zsel, zlim, zc, zr;
  logic signed [rqe_pkg::AngleW-1:0] ang_w;
  logic signed [rqe_pkg::PitchW-1:0] ang_p;
  localparam int Sh = rqe_pkg::WorkFb - rqe_pkg::AngleFb;
  always_comb begin
    zsel = zero_q ? '0 : cz_q;
    zlim = (state_q == rqe_pkg::S_PITCH) ? rqe_pkg::HalfPiQ30 : rqe_pkg::PiQ30;
    if (zsel > zlim) begin
      zc = zlim;
    end else if (zsel < -zlim) begin
      zc = -zlim;
    end else begin
      zc = zsel;
    end
    zr    = zc + rqe_pkg::CorW'(1 <<< (Sh - 1));
    ang_w = zr[Sh +: rqe_pkg::AngleW];
    ang_p = zr[Sh +: rqe_pkg::PitchW];
  end

  logic done_load;
  assign done_load = (state_q == rqe_pkg::S_DONE) && (!out_valid_q || euler_o.ready);

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rqe_pkg::S_IDLE;
      step_q      <= '0;
      pvalid_q    <= 1'b0;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
      it_q        <= '0;
    end else begin
      case (state_q)
        rqe_pkg::S_IDLE: begin
          if (in_acc) begin
            if (have_prev_q) begin
              state_q  <= rqe_pkg::S_MUL;
              step_q   <= '0;
              pvalid_q <= 1'b0;
            end else begin
              have_prev_q <= 1'b1;
            end
          end
        end
        rqe_pkg::S_MUL: begin
          pvalid_q <= issue;
          if (issue) begin
            step_q <= step_q + 1'b1;
          end
          if (mul_end) begin
            state_q <= rqe_pkg::S_ROLL;
            it_q    <= '0;
          end
        end
        rqe_pkg::S_ROLL: begin
          if (cor_run) begin
            it_q <= it_q + 1'b1;
          end
          if (cor_end) begin
            state_q <= rqe_pkg::S_YAW;
            it_q    <= '0;
          end
        end
        rqe_pkg::S_YAW: begin
          if (cor_run) begin
            it_q <= it_q + 1'b1;
          end
          if (cor_end) begin
            state_q <= rqe_pkg::S_SQRT;
          end
        end
        rqe_pkg::S_SQRT: begin
          if (sqrt_end) begin
            state_q <= rqe_pkg::S_PITCH;
            it_q    <= '0;
          end
        end
        rqe_pkg::S_PITCH: begin
          if (cor_run) begin
            it_q <= it_q + 1'b1;
          end
          if (cor_end) begin
            state_q <= rqe_pkg::S_DONE;
          end
        end
        rqe_pkg::S_DONE: begin
          if (done_load) begin
            state_q <= rqe_pkg::S_IDLE;
          end
        end
        default: state_q <= rqe_pkg::S_IDLE;
      endcase

      if (done_load) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (have_prev_q) begin
        cq_q[0] <= quat_i.quat_w;
        cq_q[1] <= quat_i.quat_x;
        cq_q[2] <= quat_i.quat_y;
        cq_q[3] <= quat_i.quat_z;
      end else begin
        pq_q[0] <= quat_i.quat_w;
        pq_q[1] <= quat_i.quat_x;
        pq_q[2] <= quat_i.quat_y;
        pq_q[3] <= quat_i.quat_z;
      end
    end

    if (issue) begin
      prod_q  <= prod_d;
      pstep_q <= ms;
      pk_q    <= step_q;
      if (step_q == rqe_pkg::StepW'(rqe_pkg::SqStep)) begin
        s_q <= s_c;
      end
    end

    if ((state_q == rqe_pkg::S_MUL) && pvalid_q) begin
      acc_q <= acc_sum;
      if (pstep_q.last) begin
        if (pk_q < rqe_pkg::StepW'(rqe_pkg::MatStep)) begin
          r_q[pk_q[3:2]] <= r_new;
        end else begin
          mat_q[grp] <= m_new;
        end
      end
      if (pk_q == rqe_pkg::StepW'(rqe_pkg::SqStep)) begin
        rad_q  <= (rqe_pkg::RadW'(1) << (2*rqe_pkg::WorkFb)) - prod_q[rqe_pkg::RadW-1:0];
        root_q <= '0;
        bit_q  <= rqe_pkg::RadW'(1) << (2*rqe_pkg::WorkFb);
      end
    end

    if ((state_q == rqe_pkg::S_SQRT) && (bit_q != '0)) begin
      if (rad_q >= sq_sum) begin
        rad_q  <= rad_q - sq_sum;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end

    if (cor_start) begin
      cx_q   <= ix0;
      cy_q   <= iy0;
      cz_q   <= iz0;
      zero_q <= izero;
    end else if (cor_run) begin
      if (cy_q > 0) begin
        cx_q <= cx_q + dy;
        cy_q <= cy_q - dx;
        cz_q <= cz_q + at;
      end else begin
        cx_q <= cx_q - dy;
        cy_q <= cy_q + dx;
        cz_q <= cz_q - at;
      end
    end

    if (cor_end) begin
      case (state_q)
        rqe_pkg::S_ROLL:  roll_a_q  <= ang_w;
        rqe_pkg::S_YAW:   yaw_a_q   <= ang_w;
        rqe_pkg::S_PITCH: pitch_a_q <= ang_p;
        default: ;
      endcase
    end

    if (done_load) begin
      roll_o_q  <= roll_a_q;
      pitch_o_q <= pitch_a_q;
      yaw_o_q   <= yaw_a_q;
      pq_q      <= cq_q;
    end
  end

endmodule

FILE: rtl/rqe_checker.sv
module rqe_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic signed [rqe_pkg::AngleW-1:0] roll_i,
  input  logic signed [rqe_pkg::PitchW-1:0] pitch_i,
  input  logic signed [rqe_pkg::AngleW-1:0] yaw_i
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its angles
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(roll_i) && $stable(pitch_i) && $stable(yaw_i))
    else $error("result changed while stalled");

  // pitch stays within half a turn
  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pitch_i <= 15'sd12868) && (pitch_i >= -15'sd12868))
    else $error("pitch out of range");

  // roll and yaw stay within a full turn
  a_ry_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (roll_i <= 16'sd25736) && (roll_i >= -16'sd25736) &&
                    (yaw_i <= 16'sd25736) && (yaw_i >= -16'sd25736))
    else $error("roll or yaw out of range");

endmodule

bind relative_quaternion_to_euler rqe_checker u_rqe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (euler_o.valid),
  .out_ready_i (euler_o.ready),
  .roll_i      (euler_o.roll_angle),
  .pitch_i     (euler_o.pitch_angle),
  .yaw_i       (euler_o.yaw_angle)
);
